@@ hw/rtl/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and the Bayer site lookup for the bilinear demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int FRAME_BITS = 13;
    localparam int SUM_BITS   = PIXEL_BITS + 2;

    // Divide by three as multiply by reciprocal and shift, exact below 2**SUM_BITS
    localparam int DIV3_SHIFT = SUM_BITS + 1;
    localparam logic [SUM_BITS-1:0] DIV3_RECIP = SUM_BITS'(((1 << DIV3_SHIFT) + 2) / 3);

    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GRBG = 2'd2;
    localparam logic [1:0] PAT_GBRG = 2'd3;

    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;

    localparam logic [FRAME_BITS-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [FRAME_BITS-1:0] HEIGHT_RESET = 13'd1080;

    typedef enum logic [1:0] {
        COL_RED,
        COL_GREEN,
        COL_BLUE
    } colour_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM0,
        ST_DIV0,
        ST_SUM1,
        ST_DIV1
    } ctrl_state_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] raw_sample;
        logic                  pad;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic                  end_of_line;
        logic                  end_of_frame;
        logic                  last_in_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0]            mosaic_order;
        logic [FRAME_BITS-1:0] frame_width;
        logic [FRAME_BITS-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic sum;
        logic second;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic has0;
        logic has1;
        logic out_free;
    } dp_status_t;

    // Colour of a site from its row and column parity under a mosaic order
    function automatic colour_t site_colour(input logic [1:0] pattern,
                                            input logic row_odd,
                                            input logic col_odd);
        logic    flip_col;
        logic    swap_rb;
        logic    c;
        colour_t col;
        case (pattern)
            PAT_RGGB: begin flip_col = 1'b0; swap_rb = 1'b0; end
            PAT_BGGR: begin flip_col = 1'b0; swap_rb = 1'b1; end
            PAT_GRBG: begin flip_col = 1'b1; swap_rb = 1'b0; end
            PAT_GBRG: begin flip_col = 1'b1; swap_rb = 1'b1; end
            default:  begin flip_col = 1'b0; swap_rb = 1'b0; end
        endcase
        c = col_odd ^ flip_col;
        if (row_odd ^ c) begin
            col = COL_GREEN;
        end else if (row_odd ^ swap_rb) begin
            col = COL_BLUE;
        end else begin
            col = COL_RED;
        end
        return col;
    endfunction

endpackage

@@ hw/rtl/bbd_line_buffer.sv @@
// ----------------------------------------------------------------------------
// bbd_line_buffer
// Line store memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbd_line_buffer #(
    parameter int DEPTH     = 4096,
    parameter int DATA_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bbd_datapath.sv @@
// ----------------------------------------------------------------------------
// bbd_datapath
// Counters, line stores, 3x3 window, neighbour sums, means and result register.
// ----------------------------------------------------------------------------
module bbd_datapath import bbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  in_item_t   s_item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  m_item,
    output logic       m_valid,
    input  logic       m_ready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = (CW + 1 > FRAME_BITS) ? CW + 1 : FRAME_BITS;
    localparam int HB = PIXEL_BITS + 1;

    // position counters
    logic [CW-1:0]         col_reg;
    logic [FRAME_BITS-1:0] row_reg;

    // geometry in use
    logic [WB-1:0]         fw;
    logic [WB-1:0]         w_eff;
    logic [FRAME_BITS-1:0] h_eff;
    logic                  last_col;
    logic                  flush;

    always_comb begin
        fw = WB'(cfg.frame_width);
        if (fw < WB'(2)) begin
            w_eff = WB'(2);
        end else if (fw > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = fw;
        end
        h_eff    = (cfg.frame_height < FRAME_BITS'(2)) ? FRAME_BITS'(2) : cfg.frame_height;
        last_col = WB'(col_reg) >= (w_eff - WB'(1));
        flush    = row_reg >= h_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= flush ? '0 : row_reg + FRAME_BITS'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // per-item flags, latched on the transaction
    logic [PIXEL_BITS-1:0] sample_reg;
    logic [CW-1:0]         idx_reg;
    logic                  c_odd_reg, r_odd_reg;
    logic                  c_ge1_reg, c_ge2_reg, r_ge2_reg;
    logic                  flush_item_reg;
    logic                  has0_reg, has1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has0_reg <= 1'b0;
            has1_reg <= 1'b0;
        end else if (cmd.accept) begin
            has0_reg <= (|row_reg) && (|col_reg);
            has1_reg <= (|row_reg) && last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg     <= s_item.pad ? '0 : s_item.raw_sample;
            idx_reg        <= col_reg;
            c_odd_reg      <= col_reg[0];
            r_odd_reg      <= row_reg[0];
            c_ge1_reg      <= |col_reg;
            c_ge2_reg      <= |col_reg[CW-1:1];
            r_ge2_reg      <= |row_reg[FRAME_BITS-1:1];
            flush_item_reg <= flush;
        end
    end

    // line stores: upper in the high half, middle in the low half
    logic [2*PIXEL_BITS-1:0] lb_rd_data;
    logic [PIXEL_BITS-1:0]   rd_upper;
    logic [PIXEL_BITS-1:0]   rd_middle;

    assign rd_upper  = lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign rd_middle = lb_rd_data[PIXEL_BITS-1:0];

    bbd_line_buffer #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_buffer (
        .aclk    (aclk),
        .rd_en   (cmd.accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (cmd.load),
        .wr_addr (idx_reg),
        .wr_data ({rd_middle, sample_reg})
    );

    // 3x3 window, column 2 newest
    logic [PIXEL_BITS-1:0] win0_reg [3];
    logic [PIXEL_BITS-1:0] win1_reg [3];
    logic [PIXEL_BITS-1:0] win2_reg [3];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            win0_reg[0] <= win0_reg[1];
            win0_reg[1] <= win0_reg[2];
            win0_reg[2] <= rd_upper;
            win1_reg[0] <= win1_reg[1];
            win1_reg[1] <= win1_reg[2];
            win1_reg[2] <= rd_middle;
            win2_reg[0] <= win2_reg[1];
            win2_reg[1] <= win2_reg[2];
            win2_reg[2] <= sample_reg;
        end
    end

    // neighbour sums for the site at window column 1 (first) or 2 (second)
    logic [PIXEL_BITS-1:0] centre, left_px, up_px, down_px, ul_px, dl_px;
    logic                  lf, rt, up, dn;
    logic [HB-1:0]         hsum, vsum;
    logic [1:0]            hn, vn;
    logic [SUM_BITS-1:0]   dsum;
    logic [2:0]            dcnt;
    colour_t               own, hcol;

    always_comb begin
        centre  = cmd.second ? win1_reg[2] : win1_reg[1];
        left_px = cmd.second ? win1_reg[1] : win1_reg[0];
        up_px   = cmd.second ? win0_reg[2] : win0_reg[1];
        down_px = cmd.second ? win2_reg[2] : win2_reg[1];
        ul_px   = cmd.second ? win0_reg[1] : win0_reg[0];
        dl_px   = cmd.second ? win2_reg[1] : win2_reg[0];
        lf      = cmd.second ? c_ge1_reg : c_ge2_reg;
        rt      = !cmd.second;
        up      = r_ge2_reg;
        dn      = !flush_item_reg;

        hsum = (lf ? HB'(left_px) : '0) + (rt ? HB'(win1_reg[2]) : '0);
        hn   = 2'(lf) + 2'(rt);
        vsum = (up ? HB'(up_px) : '0) + (dn ? HB'(down_px) : '0);
        vn   = 2'(up) + 2'(dn);
        dsum = ((up && lf) ? SUM_BITS'(ul_px) : '0)
             + ((up && rt) ? SUM_BITS'(win0_reg[2]) : '0)
             + ((dn && lf) ? SUM_BITS'(dl_px) : '0)
             + ((dn && rt) ? SUM_BITS'(win2_reg[2]) : '0);
        dcnt = 3'(up && lf) + 3'(up && rt) + 3'(dn && lf) + 3'(dn && rt);

        own  = site_colour(cfg.mosaic_order, !r_odd_reg, cmd.second ? c_odd_reg : !c_odd_reg);
        hcol = site_colour(cfg.mosaic_order, !r_odd_reg, cmd.second ? !c_odd_reg : c_odd_reg);
    end

    logic [PIXEL_BITS-1:0] centre_reg;
    logic [HB-1:0]         hsum_reg, vsum_reg;
    logic                  hn2_reg, vn2_reg;
    logic [SUM_BITS-1:0]   gsum_reg, dsum_reg;
    logic [2:0]            gn_reg, dcnt_reg;
    colour_t               own_reg, hcol_reg;
    logic                  kind_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            centre_reg <= centre;
            hsum_reg   <= hsum;
            vsum_reg   <= vsum;
            hn2_reg    <= hn == 2'd2;
            vn2_reg    <= vn == 2'd2;
            gsum_reg   <= SUM_BITS'(hsum) + SUM_BITS'(vsum);
            gn_reg     <= 3'(hn) + 3'(vn);
            dsum_reg   <= dsum;
            dcnt_reg   <= dcnt;
            own_reg    <= own;
            hcol_reg   <= hcol;
            kind_reg   <= cmd.second;
        end
    end

    // means: shifts for one, two and four; reciprocal multiply for three
    logic [2*SUM_BITS-1:0] prod3;
    logic [PIXEL_BITS-1:0] hmean, vmean, gmean, dmean;
    out_item_t             res;

    always_comb begin
        prod3 = (2*SUM_BITS)'(gsum_reg) * (2*SUM_BITS)'(DIV3_RECIP);
        hmean = hn2_reg ? hsum_reg[HB-1:1] : hsum_reg[PIXEL_BITS-1:0];
        vmean = vn2_reg ? vsum_reg[HB-1:1] : vsum_reg[PIXEL_BITS-1:0];
        case (gn_reg)
            3'd4:    gmean = gsum_reg[PIXEL_BITS+1:2];
            3'd3:    gmean = prod3[DIV3_SHIFT +: PIXEL_BITS];
            3'd2:    gmean = gsum_reg[PIXEL_BITS:1];
            default: gmean = gsum_reg[PIXEL_BITS-1:0];
        endcase
        case (dcnt_reg)
            3'd4:    dmean = dsum_reg[PIXEL_BITS+1:2];
            3'd2:    dmean = dsum_reg[PIXEL_BITS:1];
            default: dmean = dsum_reg[PIXEL_BITS-1:0];
        endcase

        res = '0;
        case (own_reg)
            COL_GREEN: begin
                res.green = centre_reg;
                if (hcol_reg == COL_RED) begin
                    res.red  = hmean;
                    res.blue = vmean;
                end else begin
                    res.red  = vmean;
                    res.blue = hmean;
                end
            end
            COL_RED: begin
                res.red   = centre_reg;
                res.green = gmean;
                res.blue  = dmean;
            end
            COL_BLUE: begin
                res.blue  = centre_reg;
                res.green = gmean;
                res.red   = dmean;
            end
            default: begin
                res.green = gmean;
            end
        endcase
        res.end_of_line  = kind_reg;
        res.end_of_frame = kind_reg && flush_item_reg;
        res.last_in_run  = kind_reg || !has1_reg;
    end

    // result register
    out_item_t m_item_reg;
    logic      m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_item_reg <= res;
        end
    end

    assign m_item          = m_item_reg;
    assign m_valid         = m_valid_reg;
    assign status.has0     = has0_reg;
    assign status.has1     = has1_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_window_takes_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (win2_reg[2] == $past(sample_reg)))
        else $error("window did not take the current sample");

endmodule

@@ hw/rtl/bbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbd_ctrl
// Sequencer: accept a pixel, update the window, then sum and divide per result.
// ----------------------------------------------------------------------------
module bbd_ctrl import bbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
                if (status.has0) begin
                    state_next = ST_SUM0;
                end else if (status.has1) begin
                    state_next = ST_SUM1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM0: begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV0;
            end
            ST_DIV0: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.has1 ? ST_SUM1 : ST_IDLE;
                end
            end
            ST_SUM1: begin
                cmd.sum    = 1'b1;
                cmd.second = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                cmd.second = 1'b1;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> cmd.load)
        else $error("window update did not follow the transaction");

    a_load_only_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> $past(cmd.accept))
        else $error("window update without a transaction");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.load, cmd.sum, cmd.emit}))
        else $error("more than one datapath command at once");

    a_second_needs_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.second) |-> status.has1)
        else $error("end-of-line result for a pixel not on the last column");

endmodule

@@ hw/rtl/bayer_bilinear_demosaic.sv @@
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Bilinear Bayer demosaic over a 3x3 window with two line stores.
// ----------------------------------------------------------------------------
// Raw pixels enter in raster order, followed per frame by one pad row, and
// RGB pixels leave one row late: the pixel at (r, c) yields output pixel
// (r-1, c-1), the last column of a row also yields (r-1, c), row 0 yields
// nothing and the pad row flushes the last real row. For each pixel the
// controller reads the line store and shifts the window, then runs a sum
// step and a divide step for each result in turn (two results for the last
// column of any row after row 0); a divide step waits while the result
// register still holds an untaken result. A new pixel is taken while the
// previous result still waits in the output register.
// Registers sit at byte addresses 0 (mosaic order), 4 (frame_width) and
// 8 (frame_height) and should be written only between frames.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic import bbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    logic [1:0]            pattern_reg;
    logic [FRAME_BITS-1:0] width_reg;
    logic [FRAME_BITS-1:0] height_reg;
    logic                  wr_en;
    cfg_t                  cfg;
    dp_cmd_t               cmd;
    dp_status_t            status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PAT_RGGB;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PATTERN: pattern_reg <= pwdata[1:0];
                REG_WIDTH:   width_reg   <= pwdata[FRAME_BITS-1:0];
                REG_HEIGHT:  height_reg  <= pwdata[FRAME_BITS-1:0];
                default: begin
                    // drop writes beyond the register map
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PATTERN: prdata = 32'(pattern_reg);
            REG_WIDTH:   prdata = 32'(width_reg);
            REG_HEIGHT:  prdata = 32'(height_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.mosaic_order  = pattern_reg;
    assign cfg.frame_width   = width_reg;
    assign cfg.frame_height  = height_reg;

    bbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bbd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule
